// File: rtl/core/tpr_pkg.sv
// Shared widths, codes and register map of the thermal PI regulator.
// No dependencies; used by tpr_serial_div and thermal_pi_regulator_core.
`default_nettype none

package tpr_pkg;

   localparam int READING_BITS      = 12;
   localparam int MAX_FRAME_SAMPLES = 255;
   localparam int ACC_BITS          = 24;

   localparam int RD_FIELD_BITS = 12;
   localparam int SUM_BITS      = 20;
   localparam int CNT_BITS      = $clog2(MAX_FRAME_SAMPLES + 1);
   localparam int DCNT_BITS     = $clog2(SUM_BITS + 1);
   localparam int ERR_BITS      = SUM_BITS + 1;
   localparam int EACC_BITS     = ((ACC_BITS > ERR_BITS) ? ACC_BITS : ERR_BITS) + 1;
   localparam int GAIN_BITS     = 9;
   localparam int PROD_BITS     = EACC_BITS + GAIN_BITS;
   localparam int TARGET_BITS   = 12;
   localparam int DAC_BITS      = 10;
   localparam int AVG_BITS      = 12;
   localparam int ADDR_BITS     = 4;

   localparam logic [RD_FIELD_BITS-1:0] RD_MASK =
      RD_FIELD_BITS'((64'd1 << READING_BITS) - 64'd1);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(MAX_FRAME_SAMPLES);

   localparam logic [1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [1:0] FUNC_START  = 2'd1;
   localparam logic [1:0] FUNC_STOP   = 2'd2;

   localparam logic [1:0] PHASE_OFF = 2'd0;
   localparam logic [1:0] PHASE_PRE = 2'd1;
   localparam logic [1:0] PHASE_REG = 2'd2;

   localparam logic [1:0] REG_TARGET = 2'd0;
   localparam logic [1:0] REG_PGAIN  = 2'd1;
   localparam logic [1:0] REG_IGAIN  = 2'd2;
   localparam logic [1:0] REG_DACMAX = 2'd3;

   typedef struct packed {
      logic                start;
      logic [SUM_BITS-1:0] dividend;
      logic [CNT_BITS-1:0] divisor;
   } div_req_type;

endpackage

`default_nettype wire

// File: rtl/core/tpr_serial_div.sv
// Restoring divider, one quotient bit per cycle: frame sum over sample count.
// Depends on tpr_pkg.
`default_nettype none

module tpr_serial_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire tpr_pkg::div_req_type         div_req,
   output logic                              done,
   output logic [tpr_pkg::SUM_BITS-1:0]      quotient
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [tpr_pkg::DCNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [tpr_pkg::SUM_BITS-1:0]   quot_ff, quot_in;
   logic [tpr_pkg::CNT_BITS-1:0]   rem_ff, rem_in;
   logic [tpr_pkg::CNT_BITS-1:0]   div_ff, div_in;
   logic [tpr_pkg::CNT_BITS:0]     trial;
   logic [tpr_pkg::CNT_BITS:0]     diff;

   assign trial = {rem_ff, quot_ff[tpr_pkg::SUM_BITS-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = tpr_pkg::DCNT_BITS'(tpr_pkg::SUM_BITS);
         quot_in = div_req.dividend;
         rem_in  = '0;
         div_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in  = diff[tpr_pkg::CNT_BITS-1:0];
            quot_in = {quot_ff[tpr_pkg::SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in  = trial[tpr_pkg::CNT_BITS-1:0];
            quot_in = {quot_ff[tpr_pkg::SUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == tpr_pkg::DCNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

// File: rtl/core/thermal_pi_regulator_core.sv
// Top level of the thermal PI regulator: stream channels, register port, sequencer.
// Depends on tpr_pkg and tpr_serial_div.
//
// Input channel req_: one item per reading or command. tuser carries func
// (0 sample, 1 start, 2 stop), tlast marks the last reading of a frame,
// tdata[11:0] the reading. Result channel rsp_: tdata holds dac_code,
// phase and frame_average. Start and stop give a result in the cycle after
// acceptance. A frame-ending sample runs the serial divider, one quotient
// bit at a time, and in regulation then the shared multiplier for the P
// and I terms; preheat skips the multiplier. Other samples give no result.
// One item is in work at a time; req_tready is low while the sequencer runs.
// The result sits in an output register; while the receiver stalls, a
// command or a frame-end result waits until it is taken.
// Reset puts the block off with empty frame sum, zero integral and register defaults.
// The user must write registers over the csr_ port while idle; not enforced by the block.
`default_nettype none

module thermal_pi_regulator_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [15:0]                     req_tdata,  // reading[11:0], zero pad
   input  wire logic [1:0]                      req_tuser,  // func[1:0]
   input  wire logic                            req_tlast,  // frame_end
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [23:0]                          rsp_tdata,  // dac_code[9:0], phase[11:10],
                                                            // frame_average[23:12]
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [tpr_pkg::ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_EVAL, S_MULP, S_MULI, S_CLAMPI, S_SUM, S_OUT
   } state_type;

   localparam int SUM_W  = tpr_pkg::SUM_BITS;
   localparam int CNT_W  = tpr_pkg::CNT_BITS;
   localparam int ERR_W  = tpr_pkg::ERR_BITS;
   localparam int EACC_W = tpr_pkg::EACC_BITS;
   localparam int PROD_W = tpr_pkg::PROD_BITS;
   localparam int ACC_W  = tpr_pkg::ACC_BITS;
   localparam int DAC_W  = tpr_pkg::DAC_BITS;
   localparam int AVG_W  = tpr_pkg::AVG_BITS;
   localparam int TGT_W  = tpr_pkg::TARGET_BITS;
   localparam int GAIN_W = tpr_pkg::GAIN_BITS;

   localparam logic signed [EACC_W-1:0] ACC_HI = EACC_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
   localparam logic signed [EACC_W-1:0] ACC_LO = -ACC_HI - EACC_W'(1);

   state_type                    state_ff, state_in;
   logic [1:0]                   mode_ff, mode_in;
   logic [SUM_W-1:0]             sum_ff, sum_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic [SUM_W-1:0]             avg_ff, avg_in;
   logic signed [ERR_W-1:0]      err_ff, err_in;
   logic signed [EACC_W-1:0]     eacc_ff, eacc_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [DAC_W-1:0]      pterm_ff, pterm_in;
   logic signed [DAC_W-1:0]      iterm_ff, iterm_in;
   logic [DAC_W-1:0]             dac_ff, dac_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [DAC_W-1:0]             rsp_dac_ff, rsp_dac_in;
   logic [1:0]                   rsp_phase_ff, rsp_phase_in;
   logic [AVG_W-1:0]             rsp_avg_ff, rsp_avg_in;

   logic [TGT_W-1:0]             target_ff;
   logic signed [GAIN_W-1:0]     p_gain_ff;
   logic signed [GAIN_W-1:0]     i_gain_ff;
   logic [DAC_W-1:0]             dac_max_ff;

   tpr_pkg::div_req_type         div_req;
   logic                         div_done;
   logic [SUM_W-1:0]             div_quot;

   logic                         req_take;
   logic                         out_free;
   logic [SUM_W:0]               sum_wide;
   logic [SUM_W-1:0]             sum_next;
   logic [CNT_W-1:0]             count_next;
   logic [tpr_pkg::RD_FIELD_BITS-1:0] reading;
   logic signed [GAIN_W-1:0]     mul_a;
   logic signed [EACC_W-1:0]     mul_b;
   logic signed [PROD_W-1:0]     mul_p;
   logic signed [ERR_W-1:0]      err_calc;
   logic signed [DAC_W+1:0]      dac_sum;
   logic [1:0]                   csr_index;
   logic                         csr_write;

   function automatic logic signed [DAC_W-1:0] clamp_term(
      input logic signed [PROD_W-1:0] v,
      input logic [DAC_W-1:0]         dmax
   );
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = $signed(PROD_W'({1'b0, dmax[DAC_W-1:1]}));
      lo = -hi - PROD_W'(1);
      if (v > hi) begin
         clamp_term = hi[DAC_W-1:0];
      end else if (v < lo) begin
         clamp_term = lo[DAC_W-1:0];
      end else begin
         clamp_term = v[DAC_W-1:0];
      end
   endfunction

   tpr_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign reading    = req_tdata[tpr_pkg::RD_FIELD_BITS-1:0] & tpr_pkg::RD_MASK;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_take   = req_tvalid && req_tready;

   assign sum_wide   = {1'b0, sum_ff} + (SUM_W + 1)'(reading);
   assign sum_next   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
   assign count_next = count_ff + 1'b1;

   assign err_calc = $signed({1'b0, avg_ff}) - $signed(ERR_W'(target_ff));

   assign mul_a = (state_ff == S_MULP) ? p_gain_ff : i_gain_ff;
   assign mul_b = (state_ff == S_MULP) ? {{(EACC_W - ERR_W){err_ff[ERR_W-1]}}, err_ff}
                                       : eacc_ff;
   assign mul_p = mul_a * mul_b;

   assign dac_sum = (DAC_W + 2)'(pterm_ff) + (DAC_W + 2)'(iterm_ff)
                  + $signed((DAC_W + 2)'(dac_max_ff[DAC_W-1:2]));

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      avg_in       = avg_ff;
      err_in       = err_ff;
      eacc_in      = eacc_ff;
      prod_in      = prod_ff;
      pterm_in     = pterm_ff;
      iterm_in     = iterm_ff;
      dac_in       = dac_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_dac_in   = rsp_dac_ff;
      rsp_phase_in = rsp_phase_ff;
      rsp_avg_in   = rsp_avg_ff;
      div_req      = '{start: 1'b0, dividend: sum_next, divisor: count_next};

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_tuser)
                  tpr_pkg::FUNC_START, tpr_pkg::FUNC_STOP: begin
                     mode_in      = (req_tuser == tpr_pkg::FUNC_START) ? tpr_pkg::PHASE_PRE
                                                                      : tpr_pkg::PHASE_OFF;
                     sum_in       = '0;
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_dac_in   = (req_tuser == tpr_pkg::FUNC_START) ? dac_max_ff : '0;
                     rsp_phase_in = mode_in;
                     rsp_avg_in   = '0;
                  end
                  tpr_pkg::FUNC_SAMPLE: begin
                     if (mode_ff != tpr_pkg::PHASE_OFF) begin
                        if (req_tlast || count_next == tpr_pkg::CNT_LAST) begin
                           div_req.start = 1'b1;
                           sum_in        = '0;
                           count_in      = '0;
                           state_in      = S_DIV;
                        end else begin
                           sum_in   = sum_next;
                           count_in = count_next;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               avg_in   = div_quot;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            err_in  = err_calc;
            eacc_in = EACC_W'(err_calc) + EACC_W'(acc_ff);
            if (mode_ff == tpr_pkg::PHASE_PRE) begin
               if (avg_ff <= SUM_W'(target_ff)) begin
                  mode_in = tpr_pkg::PHASE_REG;
                  acc_in  = '0;
               end
               dac_in   = dac_max_ff;
               state_in = S_OUT;
            end else begin
               state_in = S_MULP;
            end
         end
         S_MULP: begin
            prod_in  = mul_p;
            state_in = S_MULI;
         end
         S_MULI: begin
            pterm_in = clamp_term(prod_ff, dac_max_ff);
            prod_in  = mul_p;
            state_in = S_CLAMPI;
         end
         S_CLAMPI: begin
            iterm_in = clamp_term(prod_ff, dac_max_ff);
            state_in = S_SUM;
         end
         S_SUM: begin
            if (dac_sum < 0) begin
               dac_in = '0;
            end else if (dac_sum > $signed((DAC_W + 2)'(dac_max_ff))) begin
               dac_in = dac_max_ff;
            end else begin
               dac_in = dac_sum[DAC_W-1:0];
            end
            if (eacc_ff > ACC_HI) begin
               acc_in = ACC_HI[ACC_W-1:0];
            end else if (eacc_ff < ACC_LO) begin
               acc_in = ACC_LO[ACC_W-1:0];
            end else begin
               acc_in = eacc_ff[ACC_W-1:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dac_in   = dac_ff;
               rsp_phase_in = mode_ff;
               rsp_avg_in   = (avg_ff > SUM_W'({AVG_W{1'b1}})) ? {AVG_W{1'b1}}
                                                               : avg_ff[AVG_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= tpr_pkg::PHASE_OFF;
         sum_ff       <= '0;
         count_ff     <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      avg_ff       <= avg_in;
      err_ff       <= err_in;
      eacc_ff      <= eacc_in;
      prod_ff      <= prod_in;
      pterm_ff     <= pterm_in;
      iterm_ff     <= iterm_in;
      dac_ff       <= dac_in;
      rsp_dac_ff   <= rsp_dac_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_avg_ff   <= rsp_avg_in;
   end

   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= TGT_W'(200);
         p_gain_ff  <= GAIN_W'(1);
         i_gain_ff  <= GAIN_W'(1);
         dac_max_ff <= DAC_W'(1023);
      end else if (csr_write) begin
         case (csr_index)
            tpr_pkg::REG_TARGET: target_ff  <= csr_pwdata[TGT_W-1:0];
            tpr_pkg::REG_PGAIN:  p_gain_ff  <= csr_pwdata[GAIN_W-1:0];
            tpr_pkg::REG_IGAIN:  i_gain_ff  <= csr_pwdata[GAIN_W-1:0];
            tpr_pkg::REG_DACMAX: dac_max_ff <= csr_pwdata[DAC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         tpr_pkg::REG_TARGET: csr_prdata = 32'(target_ff);
         tpr_pkg::REG_PGAIN:  csr_prdata = 32'($unsigned(p_gain_ff));
         tpr_pkg::REG_IGAIN:  csr_prdata = 32'($unsigned(i_gain_ff));
         tpr_pkg::REG_DACMAX: csr_prdata = 32'(dac_max_ff);
         default:             csr_prdata = '0;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_avg_ff, rsp_phase_ff, rsp_dac_ff};

endmodule

`default_nettype wire

// File: dv/thermal_pi_regulator_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for thermal_pi_regulator_core: directed table, random frames under
// several register settings and an integral wind-up run, checked against a PI predictor.
// Depends on tpr_pkg and the regulator RTL only.
module thermal_pi_regulator_core_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 400;
   localparam int PHASE_QUOTA    = 85;
   localparam int WINDUP_FRAMES  = 150;

   typedef struct packed {
      logic [tpr_pkg::DAC_BITS-1:0] dac;
      logic [1:0]                   phase;
      logic [tpr_pkg::AVG_BITS-1:0] average;
   } drive_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [11:0] reading;
      logic        last;
      logic        typed;
      drive_type   want;
   } stim_row_type;

   localparam stim_row_type DIRECTED [0:17] = '{
      '{tpr_pkg::FUNC_SAMPLE, 12'hFFF, 1'b1, 1'b0, '{10'd0,    tpr_pkg::PHASE_OFF, 12'd0}},
      '{tpr_pkg::FUNC_STOP,   12'h000, 1'b0, 1'b1, '{10'd0,    tpr_pkg::PHASE_OFF, 12'd0}},
      '{tpr_pkg::FUNC_START,  12'h000, 1'b0, 1'b1, '{10'd1023, tpr_pkg::PHASE_PRE, 12'd0}},
      '{tpr_pkg::FUNC_SAMPLE, 12'hFFF, 1'b0, 1'b0, '{10'd0,    tpr_pkg::PHASE_OFF, 12'd0}},
      '{tpr_pkg::FUNC_SAMPLE, 12'hFFF, 1'b1, 1'b1, '{10'd1023, tpr_pkg::PHASE_PRE, 12'd4095}},
      '{tpr_pkg::FUNC_SAMPLE, 12'h000, 1'b1, 1'b1, '{10'd1023, tpr_pkg::PHASE_REG, 12'd0}},
      '{tpr_pkg::FUNC_SAMPLE, 12'd200, 1'b1, 1'b1, '{10'd255,  tpr_pkg::PHASE_REG, 12'd200}},
      '{tpr_pkg::FUNC_SAMPLE, 12'hFFF, 1'b1, 1'b1, '{10'd1023, tpr_pkg::PHASE_REG, 12'd4095}},
      '{tpr_pkg::FUNC_SAMPLE, 12'h000, 1'b1, 1'b0, '{10'd0,    tpr_pkg::PHASE_OFF, 12'd0}},
      '{tpr_pkg::FUNC_SAMPLE, 12'h555, 1'b0, 1'b0, '{10'd0,    tpr_pkg::PHASE_OFF, 12'd0}},
      '{tpr_pkg::FUNC_SAMPLE, 12'hAAA, 1'b1, 1'b0, '{10'd0,    tpr_pkg::PHASE_OFF, 12'd0}},
      '{tpr_pkg::FUNC_START,  12'hFFF, 1'b1, 1'b1, '{10'd1023, tpr_pkg::PHASE_PRE, 12'd0}},
      '{tpr_pkg::FUNC_SAMPLE, 12'h000, 1'b0, 1'b0, '{10'd0,    tpr_pkg::PHASE_OFF, 12'd0}},
      '{tpr_pkg::FUNC_STOP,   12'hFFF, 1'b1, 1'b1, '{10'd0,    tpr_pkg::PHASE_OFF, 12'd0}},
      '{tpr_pkg::FUNC_STOP,   12'h000, 1'b0, 1'b1, '{10'd0,    tpr_pkg::PHASE_OFF, 12'd0}},
      '{tpr_pkg::FUNC_SAMPLE, 12'h000, 1'b1, 1'b0, '{10'd0,    tpr_pkg::PHASE_OFF, 12'd0}},
      '{tpr_pkg::FUNC_START,  12'h000, 1'b0, 1'b1, '{10'd1023, tpr_pkg::PHASE_PRE, 12'd0}},
      '{tpr_pkg::FUNC_SAMPLE, 12'h123, 1'b1, 1'b0, '{10'd0,    tpr_pkg::PHASE_OFF, 12'd0}}
   };

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [15:0]                   req_tdata;
   logic [1:0]                    req_tuser;
   logic                          req_tlast;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [23:0]                   rsp_tdata;
   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [tpr_pkg::ADDR_BITS-1:0] csr_paddr;
   logic [31:0]                   csr_pwdata;
   logic [31:0]                   csr_prdata;
   logic                          csr_pready;

   bit steady   = 1'b0;
   bit hold_rsp = 1'b0;
   int mismatches = 0;
   int stalled    = 0;

   logic [tpr_pkg::TARGET_BITS-1:0]      target_q  = 12'd200;
   logic signed [tpr_pkg::GAIN_BITS-1:0] pgain_q   = 9'sd1;
   logic signed [tpr_pkg::GAIN_BITS-1:0] igain_q   = 9'sd1;
   logic [tpr_pkg::DAC_BITS-1:0]         dacmax_q  = 10'd1023;
   logic [1:0]                           mode_q    = tpr_pkg::PHASE_OFF;
   logic [tpr_pkg::SUM_BITS-1:0]         sum_q     = '0;
   logic [tpr_pkg::CNT_BITS-1:0]         count_q   = '0;
   longint                               integral_q = 0;
   drive_type                            expected_drive [$];

   thermal_pi_regulator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   task automatic regulate(input logic [1:0] func, input logic [11:0] reading,
                           input logic last, output bit produced, output drive_type res);
      longint total, average, half, err, pterm, iterm, limit;
      logic [tpr_pkg::DAC_BITS-1:0] code;
      produced = 1'b0;
      res = '0;
      if (func == tpr_pkg::FUNC_START || func == tpr_pkg::FUNC_STOP) begin
         mode_q = (func == tpr_pkg::FUNC_START) ? tpr_pkg::PHASE_PRE : tpr_pkg::PHASE_OFF;
         sum_q = '0;
         count_q = '0;
         res.dac = (func == tpr_pkg::FUNC_START) ? dacmax_q : '0;
         res.phase = mode_q;
         produced = 1'b1;
      end else if (func == tpr_pkg::FUNC_SAMPLE && mode_q != tpr_pkg::PHASE_OFF) begin
         total = longint'(sum_q) + longint'(reading & tpr_pkg::RD_MASK);
         sum_q = tpr_pkg::SUM_BITS'(clip(total, 0, (longint'(1) << tpr_pkg::SUM_BITS) - 1));
         count_q = count_q + 1'b1;
         if (last || count_q >= tpr_pkg::CNT_LAST) begin
            average = longint'(sum_q) / longint'(count_q);
            sum_q = '0;
            count_q = '0;
            code = dacmax_q;
            if (mode_q == tpr_pkg::PHASE_PRE) begin
               if (average <= longint'(target_q)) begin
                  mode_q = tpr_pkg::PHASE_REG;
                  integral_q = 0;
               end
            end else begin
               half  = longint'(dacmax_q) / 2;
               err   = average - longint'(target_q);
               pterm = clip(longint'(pgain_q) * err, -half - 1, half);
               iterm = clip(longint'(igain_q) * (err + integral_q), -half - 1, half);
               code  = tpr_pkg::DAC_BITS'(clip(pterm + iterm + longint'(dacmax_q) / 4, 0,
                                               longint'(dacmax_q)));
               limit = (longint'(1) << (tpr_pkg::ACC_BITS - 1)) - 1;
               integral_q = clip(integral_q + err, -limit - 1, limit);
            end
            res.dac = code;
            res.phase = mode_q;
            res.average = tpr_pkg::AVG_BITS'(clip(average, 0,
                                                  (longint'(1) << tpr_pkg::AVG_BITS) - 1));
            produced = 1'b1;
         end
      end
   endtask

   task automatic offer(input logic [1:0] func, input logic [11:0] reading, input logic last,
                        input logic typed = 1'b0, input drive_type want = '0);
      bit produced;
      drive_type res;
      if (!steady && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (!steady && $urandom_range(99) < 22);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= 16'(reading);
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      regulate(func, reading, last, produced, res);
      if (typed)
         expected_drive.push_back(want);
      else if (produced)
         expected_drive.push_back(res);
   endtask

   task automatic quiesce();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_drive.size() != 0);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= tpr_pkg::ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         tpr_pkg::REG_TARGET: target_q = value[tpr_pkg::TARGET_BITS-1:0];
         tpr_pkg::REG_PGAIN:  pgain_q  = value[tpr_pkg::GAIN_BITS-1:0];
         tpr_pkg::REG_IGAIN:  igain_q  = value[tpr_pkg::GAIN_BITS-1:0];
         tpr_pkg::REG_DACMAX: dacmax_q = value[tpr_pkg::DAC_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [11:0] target, input logic signed [8:0] pgain,
                            input logic signed [8:0] igain, input logic [9:0] dacmax);
      quiesce();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(tpr_pkg::REG_TARGET, 32'(target));
      write_reg(tpr_pkg::REG_PGAIN, 32'(pgain));
      write_reg(tpr_pkg::REG_IGAIN, 32'(igain));
      write_reg(tpr_pkg::REG_DACMAX, 32'(dacmax));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [11:0] pick_reading();
      int centre;
      centre = int'(target_q) + int'($urandom_range(400)) - 200;
      case ($urandom_range(9))
         0: return 12'd0;
         1: return 12'hFFF;
         2, 3: return 12'($urandom);
         default: begin
            if (mode_q == tpr_pkg::PHASE_PRE)
               return 12'($urandom_range(int'(target_q)));
            return 12'(clip(centre, 0, 4095));
         end
      endcase
   endfunction

   task automatic random_phase(input int quota);
      int sent, roll, len, cut;
      sent = 0;
      while (sent < quota) begin
         roll = $urandom_range(99);
         if ((mode_q == tpr_pkg::PHASE_OFF && roll < 60) || roll < 3) begin
            offer(tpr_pkg::FUNC_START, 12'($urandom), 1'($urandom));
            sent++;
         end else if (roll < 6) begin
            offer(tpr_pkg::FUNC_STOP, 12'($urandom), 1'($urandom));
            sent++;
         end else if (mode_q == tpr_pkg::PHASE_OFF) begin
            offer(tpr_pkg::FUNC_SAMPLE, 12'($urandom), 1'($urandom));
         end else begin
            len = ($urandom_range(999) < 4) ? tpr_pkg::MAX_FRAME_SAMPLES
                                            : $urandom_range(6, 1);
            cut = ($urandom_range(99) < 4) ? $urandom_range(len - 1) : len;
            for (int i = 0; i < cut; i++) begin
               if (len == tpr_pkg::MAX_FRAME_SAMPLES)
                  offer(tpr_pkg::FUNC_SAMPLE, pick_reading(),
                        (i == len - 1) ? 1'($urandom) : 1'b0);
               else
                  offer(tpr_pkg::FUNC_SAMPLE, pick_reading(), i == len - 1);
            end
            sent += cut;
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = tpr_pkg::FUNC_SAMPLE;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i])
         offer(DIRECTED[i].func, DIRECTED[i].reading, DIRECTED[i].last,
               DIRECTED[i].typed, DIRECTED[i].want);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: configure(12'd2048, 9'sd3, 9'sd2, 10'd1023);
            1: configure(12'd0, 9'sd255, 9'sd255, 10'd1023);
            2: configure(12'd4095, 9'h100, 9'h100, 10'd1);
            3: configure(12'd1000, -9'sd1, 9'sd1, 10'd2);
            default: configure(12'($urandom), 9'($urandom), 9'($urandom),
                               10'($urandom_range(1023, 1)));
         endcase
         steady = (p == 2);
         random_phase(PHASE_QUOTA);
         if (p == 1)
            hold_rsp = 1'b1;
         if (p == 3)
            quiesce();
         random_phase(PHASE_QUOTA);
      end

      // drive the integral high, then reverse the sign of its gain
      configure(12'd0, 9'sd1, 9'sd1, 10'd1023);
      steady = 1'b0;
      offer(tpr_pkg::FUNC_START, 12'd0, 1'b0);
      offer(tpr_pkg::FUNC_SAMPLE, 12'd0, 1'b1);
      repeat (WINDUP_FRAMES)
         offer(tpr_pkg::FUNC_SAMPLE, 12'($urandom_range(4095, 4032)), 1'b1);
      for (int i = 0; i < tpr_pkg::MAX_FRAME_SAMPLES; i++)
         offer(tpr_pkg::FUNC_SAMPLE, 12'hFFF, 1'b0);
      configure(12'd0, 9'($urandom), -9'sd1, 10'd1023);
      repeat (20) offer(tpr_pkg::FUNC_SAMPLE, pick_reading(), 1'b1);

      quiesce();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("thermal_pi_regulator_core: match");
      else
         $display("thermal_pi_regulator_core: mismatch");
      $finish;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 22);
         end
      end
   end

   always @(posedge clock) begin : check_drive
      drive_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.dac     = rsp_tdata[9:0];
         got.phase   = rsp_tdata[11:10];
         got.average = rsp_tdata[23:12];
         if (expected_drive.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: dac %0d phase %0d average %0d",
                        got.dac, got.phase, got.average);
         end else begin
            want = expected_drive.pop_front();
            if (got.dac !== want.dac || got.phase !== want.phase
                || got.average !== want.average) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"drive differs: expected dac %0d phase %0d average %0d, ",
                            "got dac %0d phase %0d average %0d"},
                           want.dac, want.phase, want.average,
                           got.dac, got.phase, got.average);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         stalled <= 0;
      end else if (stalled >= WATCHDOG_LIMIT) begin
         $display("thermal_pi_regulator_core: mismatch");
         $finish;
      end else begin
         stalled <= stalled + 1;
      end
   end

endmodule
